// ===== hdl/accel_moving_average_motion_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motion classifier checker
// Shared clocked assertion forms, one with a reset qualifier and one without.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MOVING_AVERAGE_MOTION_CLASSIFIER_DEFINES_SVH
`define ACCEL_MOVING_AVERAGE_MOTION_CLASSIFIER_DEFINES_SVH

// Property checked at every rising edge while reset is released.
`define AMAMC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define AMAMC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/amamc_pkg.sv =====
// ----------------------------------------------------------------------------
// amamc_pkg
// Types, field layout and constants shared by the motion classifier modules.
// ----------------------------------------------------------------------------
package amamc_pkg;

    localparam int RAW_W       = 16;
    localparam int AVG_W       = 17;
    localparam int CLS_W       = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Result beat layout, lowest bit first.
    localparam int AVG_LONG_LSB = 0;
    localparam int AVG_LAT_LSB  = AVG_LONG_LSB + AVG_W;
    localparam int MOTION_LSB   = AVG_LAT_LSB + AVG_W;
    localparam int TURN_LSB     = MOTION_LSB + CLS_W;
    localparam int M_USED_W     = TURN_LSB + CLS_W;

    localparam int DEF_WINDOW     = 10;
    localparam int THR_MOTION_RST = 209;
    localparam int THR_TURN_RST   = 292;

    // Per-axis class: above the positive threshold or below the negative one.
    // Longitudinal: stopped, accelerating, braking. Lateral: straight, right, left.
    typedef enum logic [CLS_W-1:0] {
        CLS_NONE = 2'd0,
        CLS_POS  = 2'd1,
        CLS_NEG  = 2'd2
    } cls_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OFFSET_LONG      = 2'd0,
        REG_OFFSET_LAT       = 2'd1,
        REG_THRESHOLD_MOTION = 2'd2,
        REG_THRESHOLD_TURN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] avg;
        cls_t                    cls;
    } lane_res_t;

endpackage

// ===== hdl/amamc_lane.sv =====
// ----------------------------------------------------------------------------
// amamc_lane
// One axis: offset correction, sample window with running sum, threshold
// compare and division of the sum by the window length.
// ----------------------------------------------------------------------------
module amamc_lane #(
    parameter int WINDOW = amamc_pkg::DEF_WINDOW
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 shift_en,
    input  logic signed [amamc_pkg::RAW_W-1:0]   raw,
    input  logic signed [amamc_pkg::RAW_W-1:0]   offset,
    input  logic [$clog2(WINDOW)+15:0]           lim,
    output amamc_pkg::lane_res_t                 res
);
    import amamc_pkg::*;

    localparam int LogW   = $clog2(WINDOW);
    localparam int MagW   = 16 + LogW;
    localparam int SumW   = MagW + 1;
    localparam int Shift  = MagW + LogW;
    localparam int RecipW = MagW + 1;
    localparam int ProdW  = MagW + RecipW;
    localparam longint RecipL =
        ((longint'(1) << Shift) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW);
    localparam logic [RecipW-1:0] RECIP_C = RecipW'(RecipL);

    logic signed [AVG_W-1:0] corr_reg;
    logic signed [AVG_W-1:0] win_reg [WINDOW];
    logic signed [SumW-1:0]  sum_reg;
    logic signed [SumW-1:0]  sum_next;
    logic signed [SumW-1:0]  lim_s;
    logic [MagW-1:0]         mag_reg;
    logic                    neg3_reg;
    cls_t                    cls3_reg;
    cls_t                    cls_next;
    logic [ProdW-1:0]        prod_reg;
    logic                    neg4_reg;
    cls_t                    cls4_reg;
    logic [AVG_W-1:0]        quot;

    // The oldest sample leaves from the end of the shift line as the new one enters.
    assign sum_next = sum_reg + SumW'(corr_reg) - SumW'(win_reg[WINDOW-1]);
    assign lim_s    = $signed({1'b0, lim});

    always_comb begin
        if (sum_reg > lim_s) begin
            cls_next = CLS_POS;
        end else if (sum_reg < -lim_s) begin
            cls_next = CLS_NEG;
        end else begin
            cls_next = CLS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            sum_reg    <= sum_next;
            win_reg[0] <= corr_reg;
            for (int i = 1; i < WINDOW; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            corr_reg <= AVG_W'(raw) - AVG_W'(offset);
            neg3_reg <= sum_reg[SumW-1];
            mag_reg  <= sum_reg[SumW-1] ? MagW'(-sum_reg) : MagW'(sum_reg);
            cls3_reg <= cls_next;
            // Exact floor division by the window length through a scaled reciprocal.
            prod_reg <= ProdW'(mag_reg) * ProdW'(RECIP_C);
            neg4_reg <= neg3_reg;
            cls4_reg <= cls3_reg;
        end
    end

    assign quot    = prod_reg[Shift+AVG_W-1:Shift];
    assign res.avg = neg4_reg ? -$signed(quot) : $signed(quot);
    assign res.cls = cls4_reg;

endmodule

// ===== hdl/amamc_merge.sv =====
// ----------------------------------------------------------------------------
// amamc_merge
// Joins the two lane results into one beat and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module amamc_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                vld_in,
    input  amamc_pkg::lane_res_t                res_long,
    input  amamc_pkg::lane_res_t                res_lat,
    output logic                                adv,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [amamc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import amamc_pkg::*;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    // The pipeline moves whenever the output register is empty or being emptied.
    assign adv = !m_tvalid_reg || m_tready;

    assign m_tdata_next = {{(M_TDATA_W - M_USED_W){1'b0}},
                           res_lat.cls, res_long.cls, res_lat.avg, res_long.avg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/accel_moving_average_motion_classifier.sv =====
// ----------------------------------------------------------------------------
// accel_moving_average_motion_classifier
// Two-axis moving average with three-way threshold classification per axis.
// ----------------------------------------------------------------------------
// Input beats carry one raw accelerometer sample per axis on s_tdata. Each
// axis runs in its own lane: the offset is subtracted, the value enters a
// shift line of WINDOW samples with a running sum, and the sum is compared
// with threshold times WINDOW and divided by WINDOW.
// Every input beat gives exactly one result beat on m_tdata, in order.
// A beat accepted passes the offset, sum, magnitude and compare, and reciprocal
// multiply registers and then the output register before m_tvalid shows it.
// Throughput: one beat per cycle while the receiver does not stall; the running
// sum is the only loop and it closes in a single add and subtract.
// When the receiver stalls, the output register holds its beat and s_tready
// drops, so the whole pipeline freezes; it resumes without loss.
// Reset clears the window and sums to zero, restores the offsets to zero and
// the thresholds to 209 and 292 counts, and empties the pipeline.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wr_data; the user
// must write only while no beats are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module accel_moving_average_motion_classifier #(
    parameter int WINDOW = amamc_pkg::DEF_WINDOW
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // raw_long[15:0], raw_lat[31:16]
    input  logic [amamc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // avg_long[16:0], avg_lat[33:17], motion_class[35:34], turn_class[37:36]
    output logic [amamc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [amamc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [amamc_pkg::CFG_W-1:0]          cfg_wr_data
);
    import amamc_pkg::*;

    localparam int LimW = 16 + $clog2(WINDOW);

    logic signed [RAW_W-1:0] offset_long_reg;
    logic signed [RAW_W-1:0] offset_lat_reg;
    logic [LimW-1:0]         lim_motion_reg;
    logic [LimW-1:0]         lim_turn_reg;
    logic [LimW-1:0]         lim_next;
    logic [3:0]              vld_reg;
    logic                    adv;
    lane_res_t               res_long;
    lane_res_t               res_lat;

    // Thresholds are kept already scaled by the window length.
    assign lim_next = LimW'(cfg_wr_data * WINDOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_long_reg <= '0;
            offset_lat_reg  <= '0;
            lim_motion_reg  <= LimW'(THR_MOTION_RST * WINDOW);
            lim_turn_reg    <= LimW'(THR_TURN_RST * WINDOW);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_OFFSET_LONG:      offset_long_reg <= $signed(cfg_wr_data);
                REG_OFFSET_LAT:       offset_lat_reg  <= $signed(cfg_wr_data);
                REG_THRESHOLD_MOTION: lim_motion_reg  <= lim_next;
                REG_THRESHOLD_TURN:   lim_turn_reg    <= lim_next;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], s_tvalid};
        end
    end

    assign s_tready = adv;

    amamc_lane #(.WINDOW(WINDOW)) u_lane_long (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .shift_en (adv && vld_reg[0]),
        .raw      ($signed(s_tdata[RAW_W-1:0])),
        .offset   (offset_long_reg),
        .lim      (lim_motion_reg),
        .res      (res_long)
    );

    amamc_lane #(.WINDOW(WINDOW)) u_lane_lat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .shift_en (adv && vld_reg[0]),
        .raw      ($signed(s_tdata[2*RAW_W-1:RAW_W])),
        .offset   (offset_lat_reg),
        .lim      (lim_turn_reg),
        .res      (res_lat)
    );

    amamc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .vld_in   (vld_reg[3]),
        .res_long (res_long),
        .res_lat  (res_lat),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/amamc_checker.sv =====
// ----------------------------------------------------------------------------
// amamc_checker
// Port-level checks of the motion classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_moving_average_motion_classifier_defines.svh"

module amamc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [amamc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import amamc_pkg::*;

    logic [CLS_W-1:0] motion;
    logic [CLS_W-1:0] turn;
    logic             avg_long_neg;
    logic             avg_lat_neg;

    assign motion       = m_tdata[MOTION_LSB +: CLS_W];
    assign turn         = m_tdata[TURN_LSB +: CLS_W];
    assign avg_long_neg = m_tdata[AVG_LONG_LSB + AVG_W - 1];
    assign avg_lat_neg  = m_tdata[AVG_LAT_LSB + AVG_W - 1];

    // The pipeline is empty right after reset.
    `AMAMC_ASSERT_ALWAYS(a_empty_after_reset, aclk, $past(!aresetn) |-> !m_tvalid, "result beat right after reset")

    // A held result beat keeps its contents.
    `AMAMC_ASSERT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Input is refused exactly when a result waits on a stalled receiver.
    `AMAMC_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")

    // A class above the positive threshold implies a non-negative mean.
    `AMAMC_ASSERT(a_pos_class_sign, aclk, aresetn, m_tvalid && (motion == CLS_POS || turn == CLS_POS) |-> !((motion == CLS_POS) && avg_long_neg) && !((turn == CLS_POS) && avg_lat_neg), "positive class with negative mean")

    // Only the three defined class codes appear.
    `AMAMC_ASSERT(a_class_code, aclk, aresetn, m_tvalid |-> (motion == CLS_NONE || motion == CLS_POS || motion == CLS_NEG) && (turn == CLS_NONE || turn == CLS_POS || turn == CLS_NEG), "undefined class code")

endmodule

bind accel_moving_average_motion_classifier amamc_checker u_amamc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
